/* hdl/grid_side_raycast_macros.svh */
// Assertion macros for the grid side raycast block.
// Plain text macros only; used by the top level.
`ifndef GRID_SIDE_RAYCAST_MACROS_SVH
`define GRID_SIDE_RAYCAST_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grid_side_raycast: assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grid_side_raycast: assertion failed");

`endif

/* hdl/gsr_pkg.sv */
// Shared types, constants and the sine function of the grid side raycast.
// No dependencies.
package gsr_pkg;

  localparam int GRID_CELLS = 65536;
  localparam int ADDR_W     = $clog2(GRID_CELLS);

  localparam logic [20:0] MAX_RANGE   = 21'd327680;
  localparam logic [18:0] SIDE_OFFSET = 19'd9830;
  localparam logic [18:0] NO_MAP_DIST = 19'd65536;
  localparam logic [19:0] MIN_CELL    = 20'd328;
  localparam logic signed [7:0] OCC_LIMIT = 8'sd50;
  localparam logic [15:0] QUARTER     = 16'd16384;

  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE   = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X    = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [15:0] SINE_TAB [17] = '{
    16'd0, 16'd3212, 16'd6393, 16'd9512, 16'd12539, 16'd15446, 16'd18204,
    16'd20787, 16'd23170, 16'd25329, 16'd27245, 16'd28898, 16'd30273,
    16'd31356, 16'd32137, 16'd32609, 16'd32767
  };

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_TRIG, ST_SMUL, ST_ADDR, ST_CHECK, ST_FIN
  } gsr_state_e;

  typedef struct packed {
    logic wr_cell;
    logic q_start;
    logic nomap;
    logic ld_q0;
    logic trig;
    logic smul;
    logic addr;
    logic adv;
    logic ray_end;
    logic ray_sel;
    logic out_load;
  } gsr_cmd_t;

  typedef struct packed {
    logic map_present;
    logic div_done;
    logic hit;
    logic at_limit;
    logic out_free;
  } gsr_sts_t;

  // Q1.15 sine of a binary angle, interpolated quarter-wave table.
  function automatic logic signed [16:0] sin_q15(input logic [15:0] a);
    logic [14:0] r;
    logic [4:0]  i;
    logic [9:0]  f;
    logic [15:0] t0;
    logic [15:0] t1;
    logic [25:0] prod;
    logic [15:0] mag;
    r = {1'b0, a[13:0]};
    if (a[14]) begin
      r = 15'd16384 - r;
    end
    i = r[14:10];
    f = r[9:0];
    if (i >= 5'd16) begin
      mag = SINE_TAB[16];
    end else begin
      t0   = SINE_TAB[i];
      t1   = SINE_TAB[5'(i + 5'd1)];
      prod = 26'(t1 - t0) * 26'(f);
      mag  = t0 + prod[25:10];
    end
    if (a[15]) begin
      return -$signed({1'b0, mag});
    end
    return $signed({1'b0, mag});
  endfunction

endpackage

/* hdl/gsr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/gsr_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
// No dependencies.
module gsr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  input  logic [19:0] divisor_i,
  output logic [32:0] quo_o,
  output logic [19:0] rem_o,
  output logic        done_o
);

  logic [32:0] quo_q, quo_d;
  logic [19:0] rem_q, rem_d;
  logic [19:0] dvs_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [20:0] sh;

  always_comb begin
    sh     = {rem_q, quo_q[32]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (sh >= {1'b0, dvs_q}) begin
        rem_d = 20'(sh - {1'b0, dvs_q});
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = sh[19:0];
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= start_i ? 1'b1 : busy_d;
      done_q <= start_i ? 1'b0 : done_d;
      cnt_q  <= start_i ? 6'd33 : cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= 20'd0;
      dvs_q <= divisor_i;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

/* hdl/gsr_ctrl.sv */
// Sequencer of the grid side raycast: issues datapath commands.
// Depends on gsr_pkg.
module gsr_ctrl
  import gsr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     opcode_i,
  output logic     in_ready_o,
  input  gsr_sts_t sts_i,
  output gsr_cmd_t cmd_o
);

  gsr_state_e state_q, state_d;
  logic       ray_q, ray_d;
  logic       acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ray_d   = ray_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && opcode_i == OP_QUERY) begin
          state_d = sts_i.map_present ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          ray_d   = 1'b0;
          state_d = ST_TRIG;
        end
      end
      ST_TRIG:  state_d = ST_SMUL;
      ST_SMUL:  state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (sts_i.hit || sts_i.at_limit) begin
          if (!ray_q) begin
            ray_d   = 1'b1;
            state_d = ST_TRIG;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          state_d = ST_ADDR;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.ray_sel = ray_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.wr_cell = acc && opcode_i == OP_WRITE;
        cmd_o.q_start = acc && opcode_i == OP_QUERY;
        cmd_o.nomap   = acc && opcode_i == OP_QUERY && !sts_i.map_present;
      end
      ST_DIV:   cmd_o.ld_q0 = sts_i.div_done;
      ST_TRIG:  cmd_o.trig  = 1'b1;
      ST_SMUL:  cmd_o.smul  = 1'b1;
      ST_ADDR:  cmd_o.addr  = 1'b1;
      ST_CHECK: begin
        cmd_o.ray_end = sts_i.hit || sts_i.at_limit;
        cmd_o.adv     = !sts_i.hit && !sts_i.at_limit;
      end
      ST_FIN:   cmd_o.out_load = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ray_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ray_q   <= ray_d;
    end
  end

endmodule

/* hdl/gsr_dpath.sv */
// Datapath of the grid side raycast: registers, grid store, ray stepping.
// Depends on gsr_pkg, gsr_ram and gsr_div.
module gsr_dpath
  import gsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gsr_cmd_t           cmd_i,
  output gsr_sts_t           sts_o,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [15:0]        cell_index_i,
  input  logic signed [7:0]  cell_value_i,
  input  logic signed [31:0] robot_x_i,
  input  logic signed [31:0] robot_y_i,
  input  logic [15:0]        robot_yaw_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               side_o,
  output logic [18:0]        side_range_o
);

  // configuration
  logic [8:0]  width_q, height_q;
  logic [19:0] cell_size_q;
  logic [31:0] origin_x_q, origin_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 9'd256;
      height_q    <= 9'd256;
      cell_size_q <= 20'd3277;
      origin_x_q  <= 32'd0;
      origin_y_q  <= 32'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GRID_WIDTH:  width_q     <= cfg_data_i[8:0];
        REG_GRID_HEIGHT: height_q    <= cfg_data_i[8:0];
        REG_CELL_SIZE:   cell_size_q <= cfg_data_i[19:0];
        REG_ORIGIN_X:    origin_x_q  <= cfg_data_i;
        REG_ORIGIN_Y:    origin_y_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic map_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= 1'b0;
    end else if (cmd_i.wr_cell) begin
      map_q <= 1'b1;
    end
  end

  // query start: offsets from the origin and their magnitudes
  logic signed [32:0] dx, dy;
  logic [32:0] mag_x, mag_y;
  logic [19:0] res_in;
  assign dx     = $signed({robot_x_i[31], robot_x_i}) - $signed({origin_x_q[31], origin_x_q});
  assign dy     = $signed({robot_y_i[31], robot_y_i}) - $signed({origin_y_q[31], origin_y_q});
  assign mag_x  = dx[32] ? 33'(-dx) : 33'(dx);
  assign mag_y  = dy[32] ? 33'(-dy) : 33'(dy);
  assign res_in = (cell_size_q < MIN_CELL) ? MIN_CELL : cell_size_q;

  logic [19:0] res_q;
  logic [15:0] yaw_q;
  logic        negx_q, negy_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      res_q  <= res_in;
      yaw_q  <= robot_yaw_i;
      negx_q <= dx[32];
      negy_q <= dy[32];
    end
  end

  logic [32:0] quo_x, quo_y;
  logic [19:0] rem_x, rem_y;
  logic        done_x, done_y;

  gsr_div u_div_x (
    .clk_i, .rst_ni, .start_i(cmd_i.q_start && map_q), .dividend_i(mag_x),
    .divisor_i(res_in), .quo_o(quo_x), .rem_o(rem_x), .done_o(done_x)
  );
  gsr_div u_div_y (
    .clk_i, .rst_ni, .start_i(cmd_i.q_start && map_q), .dividend_i(mag_y),
    .divisor_i(res_in), .quo_o(quo_y), .rem_o(rem_y), .done_o(done_y)
  );

  // floor quotient and remainder of the start point, kept for both rays
  logic [25:0] q0x, q0y;
  logic [19:0] r0x, r0y;
  logic [25:0] q0x_q, q0y_q;
  logic [19:0] r0x_q, r0y_q;

  always_comb begin
    q0x = quo_x[25:0];
    r0x = rem_x;
    if (negx_q) begin
      if (rem_x != 20'd0) begin
        q0x = 26'(-quo_x[25:0] - 26'd1);
        r0x = res_q - rem_x;
      end else begin
        q0x = 26'(-quo_x[25:0]);
      end
    end
    q0y = quo_y[25:0];
    r0y = rem_y;
    if (negy_q) begin
      if (rem_y != 20'd0) begin
        q0y = 26'(-quo_y[25:0] - 26'd1);
        r0y = res_q - rem_y;
      end else begin
        q0y = 26'(-quo_y[25:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_q0) begin
      q0x_q <= q0x;
      q0y_q <= q0y;
      r0x_q <= r0x;
      r0y_q <= r0y;
    end
  end

  // ray direction and per-step offsets
  logic [15:0]        ang;
  logic signed [16:0] tc_q, ts_q;
  logic signed [37:0] px, py;
  logic signed [21:0] sx_q, sy_q;

  assign ang = cmd_i.ray_sel ? 16'(yaw_q + 16'd3 * QUARTER) : 16'(yaw_q + QUARTER);
  assign px  = $signed({18'd0, res_q}) * 38'(tc_q);
  assign py  = $signed({18'd0, res_q}) * 38'(ts_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.trig) begin
      tc_q <= sin_q15(16'(ang + QUARTER));
      ts_q <= sin_q15(ang);
    end
    if (cmd_i.smul) begin
      sx_q <= 22'(px >>> 15);
      sy_q <= 22'(py >>> 15);
    end
  end

  // march state: cell coordinate as floor quotient and remainder per axis
  logic [25:0] qx_q, qy_q;
  logic [19:0] rx_q, ry_q;
  logic [20:0] dist_q;
  logic [25:0] ix, iy;
  logic [17:0] idx;
  logic        inb, inb_q;
  logic signed [21:0] sumx, sumy, ress;
  logic [25:0] qx_n, qy_n;
  logic [19:0] rx_n, ry_n;
  logic [7:0]  rdata;

  assign ix   = (qx_q[25] && rx_q != 20'd0) ? 26'(qx_q + 26'd1) : qx_q;
  assign iy   = (qy_q[25] && ry_q != 20'd0) ? 26'(qy_q + 26'd1) : qy_q;
  assign idx  = 18'(iy[8:0]) * 18'(width_q) + 18'(ix[8:0]);
  assign inb  = !ix[25] && (ix < {17'd0, width_q}) && !iy[25] && (iy < {17'd0, height_q})
                && (32'(idx) < 32'(GRID_CELLS));

  assign ress = $signed({2'b00, res_q});
  assign sumx = $signed({2'b00, rx_q}) + sx_q;
  assign sumy = $signed({2'b00, ry_q}) + sy_q;

  always_comb begin
    qx_n = qx_q;
    rx_n = 20'(sumx);
    if (sumx >= ress) begin
      qx_n = 26'(qx_q + 26'd1);
      rx_n = 20'(sumx - ress);
    end else if (sumx < 0) begin
      qx_n = 26'(qx_q - 26'd1);
      rx_n = 20'(sumx + ress);
    end
    qy_n = qy_q;
    ry_n = 20'(sumy);
    if (sumy >= ress) begin
      qy_n = 26'(qy_q + 26'd1);
      ry_n = 20'(sumy - ress);
    end else if (sumy < 0) begin
      qy_n = 26'(qy_q - 26'd1);
      ry_n = 20'(sumy + ress);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.smul) begin
      qx_q   <= q0x_q;
      qy_q   <= q0y_q;
      rx_q   <= r0x_q;
      ry_q   <= r0y_q;
      dist_q <= 21'd0;
    end else if (cmd_i.adv) begin
      qx_q   <= qx_n;
      qy_q   <= qy_n;
      rx_q   <= rx_n;
      ry_q   <= ry_n;
      dist_q <= dist_q + {1'b0, res_q};
    end
    if (cmd_i.addr) begin
      inb_q <= inb;
    end
  end

  gsr_ram #(.WIDTH(8), .DEPTH(GRID_CELLS)) u_grid (
    .clk_i,
    .we_i   (cmd_i.wr_cell && (32'(cell_index_i) < 32'(GRID_CELLS))),
    .waddr_i(ADDR_W'(cell_index_i)),
    .wdata_i(cell_value_i),
    .re_i   (cmd_i.addr && inb),
    .raddr_i(ADDR_W'(idx)),
    .rdata_o(rdata)
  );

  // ray results and the pending answer
  logic        hit;
  logic [18:0] ray_val, left_q;
  logic        res_side_q;
  logic [18:0] res_dist_q;

  assign hit     = inb_q && ($signed(rdata) > OCC_LIMIT);
  assign ray_val = hit ? 19'(dist_q) : 19'(MAX_RANGE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.nomap) begin
      res_side_q <= 1'b0;
      res_dist_q <= NO_MAP_DIST;
    end else if (cmd_i.ray_end) begin
      if (!cmd_i.ray_sel) begin
        left_q <= ray_val;
      end else if (left_q < ray_val) begin
        res_side_q <= 1'b0;
        res_dist_q <= 19'(left_q + SIDE_OFFSET);
      end else begin
        res_side_q <= 1'b1;
        res_dist_q <= 19'(ray_val + SIDE_OFFSET);
      end
    end
  end

  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      side_o       <= res_side_q;
      side_range_o <= res_dist_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.map_present = map_q;
  assign sts_o.div_done    = done_x && done_y;
  assign sts_o.hit         = hit;
  assign sts_o.at_limit    = (dist_q + {1'b0, res_q}) >= MAX_RANGE;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

/* hdl/grid_side_raycast.sv */
// Grid side raycast: an occupancy grid store that answers side queries.
// Inputs come in as transactions on the in channel (opcode 0 writes one
// grid cell, opcode 1 runs a side query); each query gives one result
// transaction on the out channel, a cell write gives none.
// Configuration writes use the cfg channel, always ready; the user must
// make them only while the block is idle, as the block does not enforce it.
// A cell write leaves the sequencer idle. A query with no map yet answers
// 1.0 m on the left side and goes straight to the result load. A normal
// query divides the start point by the cell size (one quotient bit a
// cycle), then per ray sets up the direction (sine, then step offsets)
// and walks steps (grid read, then occupancy check and advance), with at
// most ceil(327680 / cell_size) steps per ray, then loads the result
// register.
// One query is worked at a time; the in channel is ready only while the
// sequencer is idle.
// The result register holds a finished answer while the receiver stalls;
// cell writes are still taken then, but the next query's answer waits.
// Reset clears the configuration to its defaults and forgets the map;
// grid cells hold no reset value, and a query may read cells never written.
`include "grid_side_raycast_macros.svh"

module grid_side_raycast
  import gsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [15:0]        cell_index_i,
  input  logic signed [7:0]  cell_value_i,
  input  logic signed [31:0] robot_x_i,
  input  logic signed [31:0] robot_y_i,
  input  logic [15:0]        robot_yaw_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               side_o,
  output logic [18:0]        side_range_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  gsr_cmd_t cmd;
  gsr_sts_t sts;

  // configuration registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: walks divide, trig, per-step read and check for both rays
  gsr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .opcode_i, .in_ready_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  // datapath: registers, grid RAM, dividers, stepping and result register
  gsr_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .cell_index_i, .cell_value_i, .robot_x_i, .robot_y_i, .robot_yaw_i,
    .out_valid_o, .out_ready_i, .side_o, .side_range_o
  );

  // a cell write leaves the sequencer idle
  `GSR_ASSERT_NEXT(a_write_stays_idle, in_valid_i && in_ready_o && opcode_i == OP_WRITE, in_ready_o)
  // a query blocks further input until its answer is loaded
  `GSR_ASSERT_NEXT(a_query_busy, in_valid_i && in_ready_o && opcode_i == OP_QUERY, !in_ready_o)
  // a new answer appears only through a result load
  `GSR_ASSERT_NOW(a_out_from_load, $rose(out_valid_o), $past(cmd.out_load))
  // a ray never advances past an occupied cell
  `GSR_ASSERT_NOW(a_no_step_on_hit, cmd.adv, !sts.hit)

endmodule
